### src/p5h_pkg.sv
// shared types, constants and arithmetic helpers for the degree-5 polynomial evaluator
package p5h_pkg;

   // fixed-point format of coefficients, argument and result
   localparam int unsigned DATA_WIDTH  = 32;
   localparam int unsigned FRAC_BITS   = 16;
   localparam int unsigned ACC_WIDTH   = 64;
   localparam int unsigned COEF_COUNT  = 6;
   localparam int unsigned CELL_COUNT  = COEF_COUNT - 1;
   localparam int unsigned CSR_IDX_W   = 3;
   // pipeline stages per horner cell, plus one output stage
   localparam int unsigned CELL_STAGES = 3;
   localparam int unsigned PIPE_DEPTH  = CELL_COUNT * CELL_STAGES + 1;

   // derivative order codes
   localparam logic [1:0] OP_VALUE = 2'd0;
   localparam logic [1:0] OP_D1    = 2'd1;
   localparam logic [1:0] OP_D2    = 2'd2;
   localparam logic [1:0] OP_D3    = 2'd3;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_COEF0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF5 = 3'd5;

   // falling-factorial multiple of local coefficient i for each derivative order
   localparam logic [5:0] KMUL_TABLE [0:3][0:5] = '{
      '{6'd1, 6'd1,  6'd1,  6'd1,  6'd1, 6'd1},
      '{6'd1, 6'd2,  6'd3,  6'd4,  6'd5, 6'd0},
      '{6'd2, 6'd6,  6'd12, 6'd20, 6'd0, 6'd0},
      '{6'd6, 6'd24, 6'd60, 6'd0,  6'd0, 6'd0}
   };

   typedef logic [COEF_COUNT-1:0][DATA_WIDTH-1:0] coef_bank_type;

   typedef struct packed {
      logic [1:0]                   op;
      logic signed [DATA_WIDTH-1:0] x;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] y;
      logic                         overflow;
   } rsp_type;

   // one item between pipeline stages
   typedef struct packed {
      logic                        valid;
      logic [1:0]                  op;
      logic                        ov;
      logic signed [DATA_WIDTH-1:0] x;
      logic signed [ACC_WIDTH-1:0]  t;
   } stage_type;

   typedef struct packed {
      logic                        ov;
      logic signed [ACC_WIDTH-1:0] val;
   } sat_type;

   // coefficient op+i scaled by its derivative multiple, zero when unused
   function automatic logic signed [ACC_WIDTH-1:0] coef_scale(
      input coef_bank_type bank,
      input logic [1:0]    op,
      input logic [2:0]    idx
   );
      logic [3:0]                    sel;
      logic [5:0]                    k;
      logic signed [DATA_WIDTH-1:0]  c;
      logic signed [DATA_WIDTH+6:0]  prod;
      sel  = {2'b00, op} + {1'b0, idx};
      k    = KMUL_TABLE[op][idx];
      c    = (sel < 4'(COEF_COUNT)) ? $signed(bank[sel[2:0]]) : '0;
      prod = c * $signed({1'b0, k});
      return {{(ACC_WIDTH-DATA_WIDTH-7){prod[DATA_WIDTH+6]}}, prod};
   endfunction

   // 64-bit add saturated to the signed range
   function automatic sat_type add_sat(
      input logic signed [ACC_WIDTH-1:0] a,
      input logic signed [ACC_WIDTH-1:0] b
   );
      logic signed [ACC_WIDTH:0] sum;
      sat_type                   r;
      sum = {a[ACC_WIDTH-1], a} + {b[ACC_WIDTH-1], b};
      r.ov = sum[ACC_WIDTH] != sum[ACC_WIDTH-1];
      if (r.ov) begin
         r.val = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end else begin
         r.val = sum[ACC_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

### src/p5h_cell.sv
// one horner cell: add scaled coefficient, multiply by x in two halves, rescale and saturate
module p5h_cell import p5h_pkg::*; #(
   parameter int unsigned STEP = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  coef_bank_type coef_bank,
   input  stage_type     up_stage,
   output logic          up_en,
   output stage_type     dn_stage,
   input  logic          dn_en
);

   localparam logic [2:0] COEF_IDX = 3'(CELL_COUNT - STEP);
   localparam logic [2:0] STEP_W   = 3'(STEP);
   localparam int unsigned HALF    = ACC_WIDTH / 2;
   localparam int unsigned PROD_W  = ACC_WIDTH + DATA_WIDTH;

   typedef struct packed {
      logic                              valid;
      logic [1:0]                        op;
      logic                              ov;
      logic signed [DATA_WIDTH-1:0]      x;
      logic signed [HALF+DATA_WIDTH:0]   lo;
      logic signed [HALF+DATA_WIDTH-1:0] hi;
   } prod_type;

   stage_type a_ff, a_in;
   prod_type  b_ff, b_in;
   stage_type c_ff, c_in;
   logic      a_en, b_en, c_en;
   logic      active;
   sat_type   acc_sum;

   logic signed [PROD_W-1:0] full_prod;
   logic signed [PROD_W-1:0] shifted;
   logic                     fits;

   // stage enables: a stage moves when empty or when the next one moves
   assign c_en  = !c_ff.valid || dn_en;
   assign b_en  = !b_ff.valid || c_en;
   assign a_en  = !a_ff.valid || b_en;
   assign up_en = a_en;

   // add stage: cells above the top coefficient of this derivative pass zero
   assign active  = {1'b0, up_stage.op} <= STEP_W;
   assign acc_sum = add_sat(up_stage.t, coef_scale(coef_bank, up_stage.op, COEF_IDX));

   always_comb begin
      a_in    = up_stage;
      a_in.t  = active ? acc_sum.val : '0;
      a_in.ov = up_stage.ov | (active & acc_sum.ov);
   end

   // partial product stage: low half unsigned, high half signed
   always_comb begin
      b_in.valid = a_ff.valid;
      b_in.op    = a_ff.op;
      b_in.ov    = a_ff.ov;
      b_in.x     = a_ff.x;
      b_in.lo    = $signed({1'b0, a_ff.t[HALF-1:0]}) * a_ff.x;
      b_in.hi    = $signed(a_ff.t[ACC_WIDTH-1:HALF]) * a_ff.x;
   end

   // combine, arithmetic shift by the fraction bits and saturate to 64 bits
   assign full_prod = $signed({b_ff.hi, {HALF{1'b0}}}) + PROD_W'(b_ff.lo);
   assign shifted   = full_prod >>> FRAC_BITS;
   assign fits      = (&shifted[PROD_W-1:ACC_WIDTH-1]) || !(|shifted[PROD_W-1:ACC_WIDTH-1]);

   always_comb begin
      c_in.valid = b_ff.valid;
      c_in.op    = b_ff.op;
      c_in.x     = b_ff.x;
      c_in.ov    = b_ff.ov | !fits;
      if (fits) begin
         c_in.t = shifted[ACC_WIDTH-1:0];
      end else if (shifted[PROD_W-1]) begin
         c_in.t = {1'b1, {(ACC_WIDTH-1){1'b0}}};
      end else begin
         c_in.t = {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end
   end

   // stage registers, only the valid bits are reset
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         c_ff.valid <= 1'b0;
      end else begin
         if (a_en) begin
            a_ff <= a_in;
         end
         if (b_en) begin
            b_ff <= b_in;
         end
         if (c_en) begin
            c_ff <= c_in;
         end
      end
   end

   assign dn_stage = c_ff;

endmodule

### src/p5h_out.sv
// output stage: add the constant term, clip to 32 bits, hold the result beat
module p5h_out import p5h_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  coef_bank_type coef_bank,
   input  stage_type     up_stage,
   output logic          up_en,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_type       rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    en;
   sat_type acc_sum;
   logic    fits;

   assign en    = !rsp_valid_ff || rsp_ready;
   assign up_en = en;

   // last horner term, then clip the 64-bit sum to the result width
   assign acc_sum = add_sat(up_stage.t, coef_scale(coef_bank, up_stage.op, 3'd0));
   assign fits    = (&acc_sum.val[ACC_WIDTH-1:DATA_WIDTH-1])
                 || !(|acc_sum.val[ACC_WIDTH-1:DATA_WIDTH-1]);

   always_comb begin
      rsp_valid_in         = up_stage.valid;
      rsp_data_in.overflow = up_stage.ov | acc_sum.ov | !fits;
      if (fits) begin
         rsp_data_in.y = acc_sum.val[DATA_WIDTH-1:0];
      end else if (acc_sum.val[ACC_WIDTH-1]) begin
         rsp_data_in.y = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      end else begin
         rsp_data_in.y = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/poly5_horner_with_derivatives.sv
// top level: coefficient registers, chain of five horner cells and the output stage
//
//   channel  ports                          beat carries
//   req      req_valid req_ready req_data   op, x
//   rsp      rsp_valid rsp_ready rsp_data   y, overflow
//   csr      csr_valid csr_ready csr_index  csr_data: coefficient coef0..coef5
//
// one beat accepted per cycle unless a held-back result backs the chain up; each request passes
// through five cells of three stages each, add / partial products / rescale, then the output stage
// each stage holds its item only when the next one is full, so bubbles close up under stall
// reset clears the coefficients and all stage valid bits, no clearing pass
// csr writes are always taken; indexes above coef5 are dropped
module poly5_horner_with_derivatives import p5h_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DATA_WIDTH-1:0] csr_data
);

   localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

   coef_bank_type coef_ff, coef_in;
   stage_type     chain [0:CELL_COUNT];
   logic          chain_en [0:CELL_COUNT];
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // coefficient registers
   assign csr_ready = 1'b1;

   always_comb begin
      coef_in = coef_ff;
      if (csr_valid && csr_index <= CSR_COEF5) begin
         coef_in[csr_index] = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   // request beat enters the chain with a zero accumulator
   assign req_ready      = chain_en[0];
   assign chain[0].valid = req_valid;
   assign chain[0].op    = req_data.op;
   assign chain[0].ov    = 1'b0;
   assign chain[0].x     = req_data.x;
   assign chain[0].t     = '0;

   // horner cells, top coefficient first
   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      p5h_cell #(
         .STEP(k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .coef_bank (coef_ff),
         .up_stage  (chain[k]),
         .up_en     (chain_en[k]),
         .dn_stage  (chain[k+1]),
         .dn_en     (chain_en[k+1])
      );
   end

   p5h_out u_out (
      .clock     (clock),
      .reset     (reset),
      .coef_bank (coef_ff),
      .up_stage  (chain[CELL_COUNT]),
      .up_en     (chain_en[CELL_COUNT]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // items in flight, for the checks below
   always_comb begin
      cnt_in = cnt_ff;
      if (req_valid && req_ready && !(rsp_valid && rsp_ready)) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!(req_valid && req_ready) && rsp_valid && rsp_ready) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // a result never shows up without an item in flight
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != '0)
      else $error("result beat with no item in flight");

   // the pipeline never holds more items than it has stages
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more items in flight than pipeline stages");

   // requests are only refused when a result is held back
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("request refused while output is free");

   // a write of the constant term lands in its register
   a_coef0_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == CSR_COEF0 |=> coef_ff[0] == $past(csr_data))
      else $error("coefficient write lost");

endmodule
